>>> rtl/bba_pkg.sv
`timescale 1ns / 1ps

package bba_pkg;

    // one entry of the block table, one per granule
    typedef struct packed {
        logic       head;
        logic       free;
        logic [3:0] ord;
    } bba_entry_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_BAD_FREE = 2'd2;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

endpackage

>>> rtl/buddy_block_allocator.sv
`timescale 1ns / 1ps

// Buddy allocator over a pool of 2^POOL_ORDER granules, kept in one block
// table memory (one entry per granule: head, free, order) with a single
// write port and a single registered read port, all driven by a small
// sequencer. One request is handled at a time and in_stall is high while it
// runs. An allocation scans the table in address order at one entry a cycle,
// then writes one split half per cycle, one per order level. A free reads
// the head (S_FREE_RD, S_FREE_CK), then reads and checks the buddy
// (S_MRG_RD, S_MRG_CK) for each merge level. Every result then passes
// through S_RES, which waits out an output stall, into the output register.
// After reset the table is cleared at one entry a cycle, before any request.
module buddy_block_allocator #(
    parameter int POOL_ORDER = 10
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       action,
    input  logic [3:0] order,
    input  logic [9:0] address,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [9:0] address_res,
    output logic [1:0] status
);

    localparam int AW    = POOL_ORDER;
    localparam int DEPTH = 1 << POOL_ORDER;

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_SCAN    = 4'd2;
    localparam logic [3:0] S_SPLIT   = 4'd3;
    localparam logic [3:0] S_FREE_RD = 4'd4;
    localparam logic [3:0] S_FREE_CK = 4'd5;
    localparam logic [3:0] S_MRG_RD  = 4'd6;
    localparam logic [3:0] S_MRG_CK  = 4'd7;
    localparam logic [3:0] S_RES     = 4'd8;

    bba_pkg::bba_entry_t mem [DEPTH];
    bba_pkg::bba_entry_t rd_data_reg;

    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;        // clear / scan issue address
    logic [AW-1:0] chk_addr_reg, chk_addr_next;
    logic          chk_vld_reg, chk_vld_next;
    logic          scan_end_reg, scan_end_next;
    logic [AW-1:0] a_reg, a_next;
    logic [3:0]    k_reg, k_next;
    logic [3:0]    want_reg, want_next;
    logic [9:0]    res_addr_reg, res_addr_next;
    logic [1:0]    res_st_reg, res_st_next;
    logic          out_valid_reg, out_valid_next;
    logic [9:0]    out_addr_reg, out_addr_next;
    logic [1:0]    out_st_reg, out_st_next;

    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    bba_pkg::bba_entry_t wr_data;
    logic [AW-1:0]       rd_addr;

    logic [AW-1:0] buddy;
    logic [3:0]    k_dec;
    logic          in_acc;

    assign in_acc    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign buddy     = a_reg ^ (AW'(1) << k_reg);
    assign k_dec     = k_reg - 4'd1;
    assign out_valid   = out_valid_reg;
    assign address_res = out_addr_reg;
    assign status      = out_st_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        chk_addr_next = chk_addr_reg;
        chk_vld_next  = chk_vld_reg;
        scan_end_next = scan_end_reg;
        a_next        = a_reg;
        k_next        = k_reg;
        want_next     = want_reg;
        res_addr_next = res_addr_reg;
        res_st_next   = res_st_reg;
        wr_en         = 1'b0;
        wr_addr       = a_reg;
        wr_data       = '0;
        rd_addr       = a_reg;

        out_valid_next = out_valid_reg && out_stall;
        out_addr_next  = out_addr_reg;
        out_st_next    = out_st_reg;

        case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = cnt_reg;
                if (cnt_reg == '0)
                begin
                    wr_data = '{head: 1'b1, free: 1'b1, ord: 4'(POOL_ORDER)};
                end
                cnt_next = cnt_reg + AW'(1);
                if (&cnt_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    res_addr_next = '0;
                    if (action == bba_pkg::ACT_ALLOC)
                    begin
                        want_next = order;
                        if (order > 4'(POOL_ORDER))
                        begin
                            res_st_next = bba_pkg::ST_NO_SPACE;
                            state_next  = S_RES;
                        end
                        else
                        begin
                            cnt_next      = '0;
                            chk_vld_next  = 1'b0;
                            scan_end_next = 1'b0;
                            state_next    = S_SCAN;
                        end
                    end
                    else
                    begin
                        a_next = AW'(address);
                        if ((POOL_ORDER < 10) && ((address >> POOL_ORDER) != '0))
                        begin
                            res_st_next = bba_pkg::ST_BAD_FREE;
                            state_next  = S_RES;
                        end
                        else
                        begin
                            state_next = S_FREE_RD;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                // read pipelined one entry ahead of the check
                rd_addr       = cnt_reg;
                cnt_next      = cnt_reg + AW'(1);
                chk_addr_next = cnt_reg;
                chk_vld_next  = !scan_end_reg;
                if (&cnt_reg)
                begin
                    scan_end_next = 1'b1;
                end
                if (chk_vld_reg)
                begin
                    if (rd_data_reg.head && rd_data_reg.free && rd_data_reg.ord >= want_reg)
                    begin
                        a_next     = chk_addr_reg;
                        k_next     = rd_data_reg.ord;
                        state_next = S_SPLIT;
                    end
                    else if (&chk_addr_reg)
                    begin
                        res_st_next = bba_pkg::ST_NO_SPACE;
                        state_next  = S_RES;
                    end
                end
            end
            S_SPLIT:
            begin
                wr_en = 1'b1;
                if (k_reg > want_reg)
                begin
                    wr_addr = a_reg + (AW'(1) << k_dec);
                    wr_data = '{head: 1'b1, free: 1'b1, ord: k_dec};
                    k_next  = k_dec;
                end
                else
                begin
                    wr_addr       = a_reg;
                    wr_data       = '{head: 1'b1, free: 1'b0, ord: k_reg};
                    res_addr_next = 10'(a_reg);
                    res_st_next   = bba_pkg::ST_OK;
                    state_next    = S_RES;
                end
            end
            S_FREE_RD:
            begin
                rd_addr    = a_reg;
                state_next = S_FREE_CK;
            end
            S_FREE_CK:
            begin
                if (!rd_data_reg.head || rd_data_reg.free)
                begin
                    res_st_next = bba_pkg::ST_BAD_FREE;
                    state_next  = S_RES;
                end
                else
                begin
                    k_next     = rd_data_reg.ord;
                    state_next = S_MRG_RD;
                end
            end
            S_MRG_RD:
            begin
                rd_addr = buddy;
                if (k_reg >= 4'(POOL_ORDER))
                begin
                    wr_en       = 1'b1;
                    wr_addr     = a_reg;
                    wr_data     = '{head: 1'b1, free: 1'b1, ord: k_reg};
                    res_st_next = bba_pkg::ST_OK;
                    state_next  = S_RES;
                end
                else
                begin
                    state_next = S_MRG_CK;
                end
            end
            S_MRG_CK:
            begin
                wr_en = 1'b1;
                if (rd_data_reg.head && rd_data_reg.free && rd_data_reg.ord == k_reg)
                begin
                    // upper half loses its head; the low entry is written at the end
                    wr_addr    = (a_reg < buddy) ? buddy : a_reg;
                    wr_data    = '0;
                    a_next     = (a_reg < buddy) ? a_reg : buddy;
                    k_next     = k_reg + 4'd1;
                    state_next = S_MRG_RD;
                end
                else
                begin
                    wr_addr     = a_reg;
                    wr_data     = '{head: 1'b1, free: 1'b1, ord: k_reg};
                    res_st_next = bba_pkg::ST_OK;
                    state_next  = S_RES;
                end
            end
            S_RES:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next  = res_addr_reg;
                    out_st_next    = res_st_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            chk_vld_reg   <= 1'b0;
            scan_end_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            chk_vld_reg   <= chk_vld_next;
            scan_end_reg  <= scan_end_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_addr_reg <= chk_addr_next;
        a_reg        <= a_next;
        k_reg        <= k_next;
        want_reg     <= want_next;
        res_addr_reg <= res_addr_next;
        res_st_reg   <= res_st_next;
        out_addr_reg <= out_addr_next;
        out_st_reg   <= out_st_next;
    end

    // clear pass runs over the whole table before leaving
    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR && state_next != S_CLEAR) |-> (&cnt_reg))
        else $error("clear pass left early");

    a_split_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SPLIT) |-> (k_reg >= want_reg))
        else $error("split went below requested order");

    a_merge_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MRG_CK) |-> (k_reg < 4'(POOL_ORDER)))
        else $error("merge past pool order");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_st_reg != 2'd3))
        else $error("undefined status code");

    a_fail_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RES && res_st_reg != bba_pkg::ST_OK) |-> (res_addr_reg == '0))
        else $error("failed request with nonzero address");

endmodule

>>> sim/buddy_block_allocator_test.sv
`timescale 1ns / 1ps

module buddy_block_allocator_test;

    localparam int POOL_ORDER = 10;
    localparam int POOL_SIZE = 1 << POOL_ORDER;
    localparam int IDLE_LIMIT = 20000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       action;
    logic [3:0] order;
    logic [9:0] address;
    logic       out_valid;
    logic       out_stall;
    logic [9:0] address_res;
    logic [1:0] status;

    buddy_block_allocator #(.POOL_ORDER(POOL_ORDER)) uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .order(order), .address(address),
        .out_valid(out_valid), .out_stall(out_stall),
        .address_res(address_res), .status(status)
    );

    typedef struct packed {
        logic [9:0] addr;
        logic [1:0] st;
    } grant_t;

    // predictor copy of the block table
    logic       pool_head [POOL_SIZE];
    logic       pool_free [POOL_SIZE];
    logic [3:0] pool_ord  [POOL_SIZE];
    logic [9:0] live_blocks [$];
    grant_t     pending_grants [$];

    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  long_hold = 0;
    bit  random_stall = 1;

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    function automatic grant_t predict_alloc(input logic [3:0] want);
        grant_t g;
        int k;
        int half;
        g = '{addr: '0, st: bba_pkg::ST_NO_SPACE};
        if (want > POOL_ORDER)
            return g;
        for (int a = 0; a < POOL_SIZE; a++)
        begin
            if (pool_head[a] && pool_free[a] && pool_ord[a] >= want)
            begin
                k = int'(pool_ord[a]);
                while (k > want)
                begin
                    k--;
                    half = (a + (1 << k)) % POOL_SIZE;
                    pool_head[half] = 1;
                    pool_free[half] = 1;
                    pool_ord[half] = k[3:0];
                end
                pool_ord[a] = k[3:0];
                pool_free[a] = 0;
                g.addr = a[9:0];
                g.st = bba_pkg::ST_OK;
                live_blocks.push_back(a[9:0]);
                return g;
            end
        end
        return g;
    endfunction

    function automatic logic [1:0] predict_free(input logic [9:0] addr);
        int a;
        int k;
        int buddy;
        int low;
        int high;
        a = int'(addr);
        if (!pool_head[a] || pool_free[a])
            return bba_pkg::ST_BAD_FREE;
        pool_free[a] = 1;
        k = int'(pool_ord[a]);
        while (k < POOL_ORDER)
        begin
            buddy = (a ^ (1 << k)) % POOL_SIZE;
            if (!pool_head[buddy] || !pool_free[buddy] || pool_ord[buddy] != k)
                break;
            low = a < buddy ? a : buddy;
            high = a < buddy ? buddy : a;
            pool_head[high] = 0;
            pool_free[high] = 0;
            pool_ord[high] = 0;
            k++;
            pool_head[low] = 1;
            pool_free[low] = 1;
            pool_ord[low] = k[3:0];
            a = low;
        end
        for (int i = 0; i < live_blocks.size(); i++)
            if (live_blocks[i] == addr)
            begin
                live_blocks.delete(i);
                break;
            end
        return bba_pkg::ST_OK;
    endfunction

    // one beat in: random gap, hold until taken, predict on acceptance
    task automatic send_request(input logic act, input logic [3:0] ord_in,
                                input logic [9:0] addr_in);
        grant_t g;
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 0;
            action <= 1'($urandom);
            order <= 4'($urandom);
            address <= 10'($urandom);
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1;
        action <= act;
        order <= ord_in;
        address <= addr_in;
        do
            @(posedge clk);
        while (in_stall);
        if (act == bba_pkg::ACT_ALLOC)
            g = predict_alloc(ord_in);
        else
            g = '{addr: '0, st: predict_free(addr_in)};
        pending_grants.push_back(g);
    endtask

    // drop valid after the last beat of a burst
    task automatic release_input;
        @(negedge clk);
        in_valid <= 0;
        action <= 1'($urandom);
        order <= 4'($urandom);
        address <= 10'($urandom);
    endtask

    task automatic do_alloc(input logic [3:0] o);
        send_request(bba_pkg::ACT_ALLOC, o, 10'($urandom));
    endtask

    task automatic do_free(input logic [9:0] a);
        send_request(bba_pkg::ACT_FREE, 4'($urandom), a);
    endtask

    task automatic free_random_live;
        int i;
        logic [9:0] a;
        i = $urandom_range(0, live_blocks.size() - 1);
        a = live_blocks[i];
        do_free(a);
    endtask

    task automatic test_directed;
        do_alloc(4'd10);
        do_alloc(4'd0);
        do_free(10'd0);
        do_free(10'd0);
        do_alloc(4'd11);
        do_alloc(4'd15);
        do_alloc(4'd0);
        do_alloc(4'd0);
        do_alloc(4'd3);
        do_free(10'd1);
        do_free(10'd5);
        do_free(10'd1023);
        do_alloc(4'd9);
        do_alloc(4'd10);
        while (live_blocks.size() > 0)
            free_random_live();
        do_alloc(4'd10);
        do_alloc(4'd0);
        free_random_live();
        do_alloc(4'd0);
        do_free(10'd0);
        do_free(10'h3FF);
    endtask

    task automatic test_random(input int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                do_alloc(4'($urandom_range(0, 4) == 0 ? $urandom_range(0, 15)
                                                      : $urandom_range(0, 5)));
            else if (r < 88 && live_blocks.size() > 0)
                free_random_live();
            else
                do_free(10'($urandom));
        end
    endtask

    task automatic test_backpressure;
        long_hold = 1;
        for (int i = 0; i < 8; i++)
            do_alloc(4'($urandom_range(0, 3)));
        release_input();
        wait (!long_hold);
        while (live_blocks.size() > 0)
            free_random_live();
    endtask

    // receiver side stall pattern
    initial
    begin
        out_stall = 1;
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                out_stall <= 1;
                repeat (3000) @(negedge clk);
                long_hold = 0;
            end
            else if (random_stall && $urandom_range(0, 2) == 0)
            begin
                out_stall <= 1;
                repeat ($urandom_range(1, 17)) @(negedge clk);
                out_stall <= 0;
            end
            else
                out_stall <= 0;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_grants.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: address_res=%0d status=%0d",
                             address_res, status);
            end
            else
            begin
                grant_t e;
                e = pending_grants.pop_front();
                if (e.addr !== address_res || e.st !== status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected addr=%0d st=%0d, got addr=%0d st=%0d",
                                 e.addr, e.st, address_res, status);
                end
            end
        end
    end

    // watchdog: cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        rst_n = 0;
        in_valid = 0;
        action = 0;
        order = 0;
        address = 0;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            pool_head[i] = (i == 0);
            pool_free[i] = (i == 0);
            pool_ord[i] = (i == 0) ? POOL_ORDER[3:0] : 4'd0;
        end
        repeat (11) @(negedge clk);
        rst_n = 1;
        test_directed();
        test_backpressure();
        test_random(540);
        release_input();
        wait (pending_grants.size() == 0);
        repeat (50) @(negedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
